// File: sv/owtr_pkg.sv
`timescale 1ns / 1ps

package owtr_pkg;

  // Bus sequencer phase codes
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_R_HIGH  = 5'd1;
  localparam logic [4:0] PH_R_LOW   = 5'd2;
  localparam logic [4:0] PH_R_REL   = 5'd3;
  localparam logic [4:0] PH_R_WAIT  = 5'd4;
  localparam logic [4:0] PH_W_PRE   = 5'd5;
  localparam logic [4:0] PH_W_LOW   = 5'd6;
  localparam logic [4:0] PH_W_BIT   = 5'd7;
  localparam logic [4:0] PH_W_END   = 5'd8;
  localparam logic [4:0] PH_RD_PRE  = 5'd9;
  localparam logic [4:0] PH_RD_LOW  = 5'd10;
  localparam logic [4:0] PH_RD_REL  = 5'd11;
  localparam logic [4:0] PH_RD_WAIT = 5'd12;

  // Configuration register indexes
  localparam logic [1:0] REG_UNIT_TICKS  = 2'd0;
  localparam logic [1:0] REG_SHORT_GAP   = 2'd1;
  localparam logic [1:0] REG_NOP_TICKS   = 2'd2;

  // Register reset values
  localparam logic [15:0] UNIT_TICKS_RST  = 16'd550;
  localparam logic [15:0] SHORT_GAP_RST   = 16'd200;
  localparam logic [15:0] NOP_TICKS_RST   = 16'd50;

  // Sensor command bytes
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  // Unit counts of the timed phases
  localparam logic [5:0] UNITS_GAP   = 6'd1;
  localparam logic [5:0] UNITS_LONG  = 6'd50;
  localparam logic [5:0] UNITS_SLOT  = 6'd6;

  // Byte sequence steps
  localparam logic [2:0] STEP_SKIP1   = 3'd0;
  localparam logic [2:0] STEP_CONVERT = 3'd1;
  localparam logic [2:0] STEP_SKIP2   = 3'd2;
  localparam logic [2:0] STEP_READ_SP = 3'd3;
  localparam logic [2:0] STEP_RD_LOW  = 3'd4;
  localparam logic [2:0] STEP_RD_HIGH = 3'd5;

  // Raw words above this are read as negative (sixteenths of a degree)
  localparam logic [15:0] NEG_THRESHOLD = 16'd60000;

  typedef struct packed {
    logic start_req;
    logic line_in;
  } in_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [15:0]        raw_word;
    logic signed [16:0] temp_sixteenths;
  } out_item_t;

endpackage

// File: sv/one_wire_temperature_reader.sv
`timescale 1ns / 1ps
// An input transfer reaches its result through two registers (input register, result register).
// One item per cycle while the output is not stalled; each item is one tick of the bus sequencer, whose next
// state is formed by one pass of combinational logic from the input register.
// Reset (asynchronous, active low) returns the sequencer to idle, clears its state and
// both valid flags, and loads the timing registers with 550, 200 and 50 ticks.

module one_wire_temperature_reader
  import owtr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Timing registers
  logic [15:0] unit_ticks_q, short_gap_q, nop_ticks_q;

  // Pipeline registers
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  out_item_t out_q;
  logic      advance;

  // Sequencer state
  logic [4:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [5:0]  unit_q, unit_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  step_q, step_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] word_q, word_d;

  // Effective state once a start request from idle is applied
  logic [4:0]  eff_phase;
  logic [15:0] eff_tick;
  logic [5:0]  eff_unit;
  logic [2:0]  eff_bit, eff_step;

  logic [15:0] len_sel, len_eff;
  logic [16:0] tick_inc;
  logic        tick_hit, units_hit, uses_tick, uses_unit;
  logic [5:0]  unit_inc, unit_lim;
  logic        drive, done;
  out_item_t   res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= UNIT_TICKS_RST;
      short_gap_q  <= SHORT_GAP_RST;
      nop_ticks_q  <= NOP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNIT_TICKS: unit_ticks_q <= cfg_data_i;
        REG_SHORT_GAP:  short_gap_q  <= cfg_data_i;
        REG_NOP_TICKS:  nop_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: a held item moves on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Start request from idle restarts the counters
  always_comb begin
    if (phase_q == PH_IDLE && in_q.start_req) begin
      eff_phase = PH_R_HIGH;
      eff_tick  = '0;
      eff_unit  = '0;
      eff_bit   = '0;
      eff_step  = STEP_SKIP1;
    end else begin
      eff_phase = phase_q;
      eff_tick  = tick_q;
      eff_unit  = unit_q;
      eff_bit   = bit_q;
      eff_step  = step_q;
    end
  end

  // Tick and unit counters of the current phase
  always_comb begin
    case (eff_phase)
      PH_W_PRE, PH_RD_PRE:             len_sel = nop_ticks_q;
      PH_W_LOW, PH_RD_LOW, PH_RD_REL:  len_sel = short_gap_q;
      default:                         len_sel = unit_ticks_q;
    endcase
    case (eff_phase)
      PH_R_LOW, PH_R_WAIT:             unit_lim = UNITS_LONG;
      PH_R_REL, PH_W_BIT, PH_RD_WAIT:  unit_lim = UNITS_SLOT;
      default:                         unit_lim = UNITS_GAP;
    endcase
  end

  assign len_eff   = (len_sel == 16'd0) ? 16'd1 : len_sel;
  assign tick_inc  = {1'b0, eff_tick} + 17'd1;
  assign tick_hit  = tick_inc >= {1'b0, len_eff};
  assign unit_inc  = eff_unit + 6'd1;
  assign units_hit = tick_hit && (unit_inc >= unit_lim);
  assign uses_tick = (eff_phase != PH_IDLE) && (eff_phase <= PH_RD_WAIT);
  assign uses_unit = eff_phase inside {PH_R_HIGH, PH_R_LOW, PH_R_REL, PH_R_WAIT,
                                       PH_W_BIT, PH_W_END, PH_RD_WAIT};

  // Next state of the sequencer for one tick
  always_comb begin
    phase_d = eff_phase;
    tick_d  = eff_tick;
    unit_d  = eff_unit;
    bit_d   = eff_bit;
    step_d  = eff_step;
    shift_d = shift_q;
    low_d   = low_q;
    word_d  = word_q;
    drive   = 1'b0;
    done    = 1'b0;

    if (uses_tick) begin
      tick_d = tick_hit ? 16'd0 : tick_inc[15:0];
    end
    if (uses_unit && tick_hit) begin
      unit_d = units_hit ? 6'd0 : unit_inc;
    end

    case (eff_phase)
      PH_IDLE: ;
      PH_R_HIGH: begin
        if (units_hit) phase_d = PH_R_LOW;
      end
      PH_R_LOW: begin
        drive = 1'b1;
        if (units_hit) phase_d = PH_R_REL;
      end
      PH_R_REL: begin
        if (units_hit) phase_d = in_q.line_in ? PH_R_HIGH : PH_R_WAIT;
      end
      PH_R_WAIT: begin
        if (units_hit) begin
          if (in_q.line_in) begin
            shift_d = CMD_SKIP_ROM;
            bit_d   = '0;
            phase_d = PH_W_PRE;
          end else begin
            phase_d = PH_R_HIGH;
          end
        end
      end
      PH_W_PRE: begin
        if (tick_hit) phase_d = PH_W_LOW;
      end
      PH_W_LOW: begin
        drive = 1'b1;
        if (tick_hit) phase_d = PH_W_BIT;
      end
      PH_W_BIT: begin
        drive = ~shift_q[0];
        if (units_hit) begin
          shift_d = {1'b0, shift_q[7:1]};
          if (eff_bit == 3'd7) begin
            bit_d   = '0;
            phase_d = PH_W_END;
          end else begin
            bit_d   = eff_bit + 3'd1;
            phase_d = PH_W_PRE;
          end
        end
      end
      PH_W_END: begin
        if (units_hit) begin
          case (eff_step)
            STEP_SKIP1: begin
              step_d  = STEP_CONVERT;
              shift_d = CMD_CONVERT;
              bit_d   = '0;
              phase_d = PH_W_PRE;
            end
            STEP_CONVERT: begin
              step_d  = STEP_SKIP2;
              phase_d = PH_R_HIGH;
            end
            STEP_SKIP2: begin
              step_d  = STEP_READ_SP;
              shift_d = CMD_READ_SP;
              bit_d   = '0;
              phase_d = PH_W_PRE;
            end
            STEP_READ_SP: begin
              step_d  = STEP_RD_LOW;
              shift_d = '0;
              bit_d   = '0;
              phase_d = PH_RD_PRE;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
      PH_RD_PRE: begin
        if (tick_hit) phase_d = PH_RD_LOW;
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        if (tick_hit) phase_d = PH_RD_REL;
      end
      PH_RD_REL: begin
        if (tick_hit) begin
          shift_d = {in_q.line_in, shift_q[7:1]};
          phase_d = PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        if (units_hit) begin
          if (eff_bit == 3'd7) begin
            bit_d = '0;
            if (eff_step == STEP_RD_LOW) begin
              low_d   = shift_q;
              shift_d = '0;
              step_d  = STEP_RD_HIGH;
              phase_d = PH_RD_PRE;
            end else if (eff_step == STEP_RD_HIGH) begin
              word_d  = {shift_q, low_q};
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_IDLE;
            end
          end else begin
            bit_d   = eff_bit + 3'd1;
            phase_d = PH_RD_PRE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Result item; raw words above the threshold wrap to negative values
  always_comb begin
    res.drive_low       = drive;
    res.busy_res        = (eff_phase != PH_IDLE);
    res.done_res        = done;
    res.raw_word        = word_d;
    res.temp_sixteenths = signed'({(word_d > NEG_THRESHOLD), word_d});
  end

  // Sequencer state advances once per transferred item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      unit_q  <= '0;
      bit_q   <= '0;
      step_q  <= STEP_SKIP1;
      shift_q <= '0;
      low_q   <= '0;
      word_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      unit_q  <= unit_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      low_q   <= low_d;
      word_q  <= word_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A finished result is always reported inside a busy sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> out_q.busy_res)
    else $error("done without busy");

  // The line is only pulled low while a sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.drive_low |-> out_q.busy_res)
    else $error("line driven while idle");

  // The sequencer never leaves the defined phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_RD_WAIT)
    else $error("phase out of range");

  // The result word only changes on a completed read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !done |=> $stable(word_q))
    else $error("result word changed without done");
`endif

endmodule

// File: bench/one_wire_temperature_reader_tb.sv
`timescale 1ns / 1ps

module one_wire_temperature_reader_tb;
  import owtr_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = REG_UNIT_TICKS;
  logic [15:0] cfg_data_i  = '0;

  // Timing registers as the bus master sees them.
  logic [15:0] cfg_unit = UNIT_TICKS_RST;
  logic [15:0] cfg_gap  = SHORT_GAP_RST;
  logic [15:0] cfg_nop  = NOP_TICKS_RST;

  // Own copy of the sequencer state.
  logic [4:0]  seq_phase = PH_IDLE;
  logic [15:0] tick_cnt  = '0;
  logic [5:0]  unit_cnt  = '0;
  logic [2:0]  bit_idx   = '0;
  logic [2:0]  byte_step = STEP_SKIP1;
  logic [7:0]  shift_reg = '0;
  logic [7:0]  low_byte  = '0;
  logic [15:0] word_q    = '0;

  // Emulated sensor and run control.
  logic [15:0] sensor_word   = '0;
  bit          sensor_absent = 1'b0;
  bit          src_eager     = 1'b0;
  bit          sink_eager    = 1'b0;
  int unsigned hold_cycles   = 0;
  int unsigned readings_done = 0;
  int unsigned error_count   = 0;

  out_item_t pending_outputs[$];

  one_wire_temperature_reader u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // A tick length of zero behaves as one tick.
  function automatic logic ticks_over(input logic [15:0] len);
    logic [16:0] next_cnt;
    next_cnt = {1'b0, tick_cnt} + 17'd1;
    if (next_cnt >= ((len == 16'd0) ? 17'd1 : {1'b0, len})) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = next_cnt[15:0];
    return 1'b0;
  endfunction

  function automatic logic units_over(input logic [5:0] n);
    if (ticks_over(cfg_unit)) begin
      unit_cnt = unit_cnt + 6'd1;
      if (unit_cnt >= n) begin
        unit_cnt = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void begin_write(input logic [7:0] cmd);
    shift_reg = cmd;
    bit_idx   = '0;
    seq_phase = PH_W_PRE;
  endfunction

  // One tick of the bus master: advances the state and returns the output of that tick.
  function automatic out_item_t predict_bus_tick(input in_item_t it);
    out_item_t r;
    logic      drive;
    logic      done;
    int        temp;
    drive = 1'b0;
    done  = 1'b0;
    if (seq_phase == PH_IDLE && it.start_req) begin
      seq_phase = PH_R_HIGH;
      tick_cnt  = '0;
      unit_cnt  = '0;
      bit_idx   = '0;
      byte_step = STEP_SKIP1;
    end
    r.busy_res = (seq_phase != PH_IDLE);
    case (seq_phase)
      PH_IDLE: begin
      end
      PH_R_HIGH: begin
        if (units_over(UNITS_GAP)) seq_phase = PH_R_LOW;
      end
      PH_R_LOW: begin
        drive = 1'b1;
        if (units_over(UNITS_LONG)) seq_phase = PH_R_REL;
      end
      PH_R_REL: begin
        if (units_over(UNITS_SLOT)) seq_phase = it.line_in ? PH_R_HIGH : PH_R_WAIT;
      end
      PH_R_WAIT: begin
        if (units_over(UNITS_LONG)) begin
          if (it.line_in) begin_write(CMD_SKIP_ROM);
          else seq_phase = PH_R_HIGH;
        end
      end
      PH_W_PRE: begin
        if (ticks_over(cfg_nop)) seq_phase = PH_W_LOW;
      end
      PH_W_LOW: begin
        drive = 1'b1;
        if (ticks_over(cfg_gap)) seq_phase = PH_W_BIT;
      end
      PH_W_BIT: begin
        drive = ~shift_reg[0];
        if (units_over(UNITS_SLOT)) begin
          shift_reg = shift_reg >> 1;
          if (bit_idx >= 3'd7) begin
            bit_idx   = '0;
            seq_phase = PH_W_END;
          end else begin
            bit_idx++;
            seq_phase = PH_W_PRE;
          end
        end
      end
      PH_W_END: begin
        if (units_over(UNITS_GAP)) begin
          case (byte_step)
            STEP_SKIP1: begin
              byte_step = STEP_CONVERT;
              begin_write(CMD_CONVERT);
            end
            STEP_CONVERT: begin
              byte_step = STEP_SKIP2;
              seq_phase = PH_R_HIGH;
            end
            STEP_SKIP2: begin
              byte_step = STEP_READ_SP;
              begin_write(CMD_READ_SP);
            end
            STEP_READ_SP: begin
              byte_step = STEP_RD_LOW;
              shift_reg = '0;
              bit_idx   = '0;
              seq_phase = PH_RD_PRE;
            end
            default: seq_phase = PH_IDLE;
          endcase
        end
      end
      PH_RD_PRE: begin
        if (ticks_over(cfg_nop)) seq_phase = PH_RD_LOW;
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        if (ticks_over(cfg_gap)) seq_phase = PH_RD_REL;
      end
      PH_RD_REL: begin
        if (ticks_over(cfg_gap)) begin
          shift_reg = {it.line_in, shift_reg[7:1]};
          seq_phase = PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        if (units_over(UNITS_SLOT)) begin
          if (bit_idx >= 3'd7) begin
            bit_idx = '0;
            if (byte_step == STEP_RD_LOW) begin
              low_byte  = shift_reg;
              shift_reg = '0;
              byte_step = STEP_RD_HIGH;
              seq_phase = PH_RD_PRE;
            end else if (byte_step == STEP_RD_HIGH) begin
              word_q    = {shift_reg, low_byte};
              done      = 1'b1;
              seq_phase = PH_IDLE;
            end else begin
              seq_phase = PH_IDLE;
            end
          end else begin
            bit_idx++;
            seq_phase = PH_RD_PRE;
          end
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    temp = int'(word_q);
    if (word_q > NEG_THRESHOLD) temp = temp - 65536;
    r.drive_low       = drive;
    r.done_res        = done;
    r.raw_word        = word_q;
    r.temp_sixteenths = temp[16:0];
    return r;
  endfunction

  // Line level that a well-behaved sensor would give, with occasional missing presence.
  function automatic logic sensor_line();
    if (sensor_absent) return 1'b1;
    case (seq_phase)
      PH_IDLE: begin
        case ($urandom_range(0, 5))
          0: sensor_word = NEG_THRESHOLD;
          1: sensor_word = NEG_THRESHOLD + 16'd1;
          2: sensor_word = 16'hFFFF;
          3: sensor_word = 16'h0000;
          default: sensor_word = 16'($urandom);
        endcase
        return 1'($urandom_range(0, 1));
      end
      PH_R_REL:  return ($urandom_range(0, 19) != 0) ? 1'b0 : 1'b1;
      PH_R_WAIT: return ($urandom_range(0, 19) != 0) ? 1'b1 : 1'b0;
      PH_RD_REL: return sensor_word[{byte_step == STEP_RD_HIGH, bit_idx}];
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Offer one tick after a random gap and hold it until the transfer.
  task automatic send_item(input in_item_t it);
    out_item_t   exp_item;
    int unsigned gap;
    exp_item = predict_bus_tick(it);
    gap = src_eager ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_outputs.push_back(exp_item);
    if (exp_item.done_res) readings_done++;
  endtask

  // Registers are only written once every pending output has come out.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_UNIT_TICKS: cfg_unit = val;
      REG_SHORT_GAP:  cfg_gap  = val;
      REG_NOP_TICKS:  cfg_nop  = val;
      default: begin
      end
    endcase
  endtask

  // Random ticks with the emulated sensor; idle ticks without a start are not counted.
  task automatic run_items(input int unsigned n, input int unsigned done_goal);
    in_item_t    it;
    int unsigned counted;
    int unsigned done_start;
    counted    = 0;
    done_start = readings_done;
    while (counted < n && (done_goal == 0 || readings_done - done_start < done_goal)) begin
      it.start_req = ($urandom_range(0, 3) == 0);
      it.line_in   = sensor_line();
      if (seq_phase != PH_IDLE || it.start_req) counted++;
      send_item(it);
    end
  endtask

  // Idle ticks at both line levels, a start, then a start while busy.
  task automatic test_idle_inputs();
    in_item_t it;
    it.start_req = 1'b0;
    it.line_in   = 1'b0;
    send_item(it);
    it.line_in = 1'b1;
    send_item(it);
    it.start_req = 1'b1;
    send_item(it);
    it.line_in = 1'b0;
    send_item(it);
  endtask

  // Zero in every timing register counts as a single tick.
  task automatic test_zero_registers();
    in_item_t it;
    write_reg(REG_UNIT_TICKS, 16'd0);
    write_reg(REG_SHORT_GAP, 16'd0);
    write_reg(REG_NOP_TICKS, 16'd0);
    for (int i = 0; i < 12; i++) begin
      it.start_req = i[0];
      it.line_in   = i[1];
      send_item(it);
    end
  endtask

  // Largest register values; the tick counter climbs without finishing a unit.
  task automatic test_full_registers();
    in_item_t it;
    write_reg(REG_UNIT_TICKS, 16'hFFFF);
    write_reg(REG_SHORT_GAP, 16'hFFFF);
    write_reg(REG_NOP_TICKS, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      it.start_req = i[1];
      it.line_in   = i[0];
      send_item(it);
    end
  endtask

  // A whole measurement sequence at the fastest timing.
  task automatic test_measurements();
    write_reg(REG_UNIT_TICKS, 16'd1);
    write_reg(REG_SHORT_GAP, 16'd1);
    write_reg(REG_NOP_TICKS, 16'd1);
    run_items(760, 1);
  endtask

  // With no presence pulse the reset repeats and starts are ignored.
  task automatic test_no_sensor();
    sensor_absent = 1'b1;
    run_items(80, 0);
    sensor_absent = 1'b0;
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_back_pressure();
    src_eager   = 1'b1;
    hold_cycles = 90;
    run_items(100, 0);
    src_eager = 1'b0;
  endtask

  // Random small timing, first without any idling, then with it.
  task automatic test_mixed_timing();
    write_reg(REG_UNIT_TICKS, 16'($urandom_range(1, 3)));
    write_reg(REG_SHORT_GAP, 16'($urandom_range(1, 5)));
    write_reg(REG_NOP_TICKS, 16'($urandom_range(1, 5)));
    src_eager  = 1'b1;
    sink_eager = 1'b1;
    run_items(60, 0);
    src_eager  = 1'b0;
    sink_eager = 1'b0;
    run_items(60, 0);
  endtask

  // Receiver: random stalls before each transfer, with a long hold when requested.
  initial begin : sink_proc
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = sink_eager ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Each output transfer is compared with the oldest pending output.
  always @(posedge clk_i) begin : check_outputs
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("output transfer with nothing pending");
      end else begin
        want = pending_outputs.pop_front();
        if (out_data_o.drive_low !== want.drive_low)
          report_mismatch($sformatf("drive_low %b, expected %b",
                                    out_data_o.drive_low, want.drive_low));
        if (out_data_o.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, expected %b",
                                    out_data_o.busy_res, want.busy_res));
        if (out_data_o.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, expected %b",
                                    out_data_o.done_res, want.done_res));
        if (out_data_o.raw_word !== want.raw_word)
          report_mismatch($sformatf("raw_word %h, expected %h",
                                    out_data_o.raw_word, want.raw_word));
        if (out_data_o.temp_sixteenths !== want.temp_sixteenths)
          report_mismatch($sformatf("temp_sixteenths %0d, expected %0d",
                                    out_data_o.temp_sixteenths, want.temp_sixteenths));
      end
    end
  end

  // Test sequence.
  initial begin : test_sequence
    int unsigned waited;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_inputs();
    test_zero_registers();
    test_full_registers();
    test_measurements();
    test_no_sensor();
    test_back_pressure();
    test_mixed_timing();
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_outputs.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_outputs.size() != 0) report_mismatch("outputs still pending at the end");
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
